// ----- hw/rtl/lmss_pkg.sv -----
// Shared types, constants and helper functions for the LED matrix scroll scanner.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package lmss_pkg;

  localparam int MATRIX_SIZE = 8;
  localparam int MAX_COLUMNS = 64;
  localparam int IDX_W       = 6;   // sentence store address
  localparam int COL_W       = 3;   // active column
  localparam int CNT_W       = 16;  // dwell and frame counters
  localparam int LEN_W       = 7;   // sentence length register

  localparam logic [3:0] ADDR_DWELL_TICKS     = 4'h0;
  localparam logic [3:0] ADDR_SENTENCE_LENGTH = 4'h4;
  localparam logic [3:0] ADDR_FRAME_REPEATS   = 4'h8;
  localparam logic [3:0] ADDR_SCROLL_ENABLE   = 4'hC;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] dwell_ticks;
    logic [LEN_W-1:0] sentence_length;
    logic [CNT_W-1:0] frame_repeats;
    logic             scroll_enable;
  } cfg_t;

  // Store read request, issued in the cycle after an item is accepted
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] addr;
    logic [COL_W-1:0] column;
    logic             pass;
  } rd_req_t;

  // Result as it leaves the store read stage
  typedef struct packed {
    logic       valid;
    logic [7:0] row_drive;
    logic [7:0] column_enable_n;
    logic       pass_done;
  } out_item_t;

  // Clamp the programmed length to 1..MAX_COLUMNS
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = len;
    if (n == '0) n = LEN_W'(1);
    if (n > LEN_W'(MAX_COLUMNS)) n = LEN_W'(MAX_COLUMNS);
    return n;
  endfunction

  // One restoring remainder step: shift in the next dividend bit, subtract n if it fits
  function automatic logic [LEN_W:0] rem_step(input logic [LEN_W:0]   rem,
                                              input logic             bit_in,
                                              input logic [LEN_W-1:0] n);
    logic [LEN_W:0] r;
    r = {rem[LEN_W-1:0], bit_in};
    if (r >= {1'b0, n}) r = r - {1'b0, n};
    return r;
  endfunction

  // Advance an index that is already below n, wrapping to zero at n
  function automatic logic [IDX_W-1:0] inc_wrap(input logic [IDX_W-1:0] v,
                                                input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] s;
    s = LEN_W'(v) + LEN_W'(1);
    return (s >= n) ? '0 : s[IDX_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] at_least_one(input logic [CNT_W-1:0] v);
    return (v == '0) ? CNT_W'(1) : v;
  endfunction

endpackage

// ----- hw/rtl/lmss_ctrl.sv -----
// Scan counters: dwell, active column, frame count, window start and store read index.
// Updates once per accepted tick, re-reduces the window after register writes. Uses lmss_pkg.
`timescale 1ns / 1ps

module lmss_ctrl
  import lmss_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    cfg_wr,
  input  logic    item_accept,
  input  logic    item_tick,
  output logic    busy,
  output rd_req_t rd_req
);

  logic [CNT_W-1:0] dwell_count, dwell_count_next;
  logic [CNT_W-1:0] frame_count, frame_count_next;
  logic [COL_W-1:0] active_column, active_column_next;
  logic [IDX_W-1:0] window_start, window_start_next;
  logic [IDX_W-1:0] ws_mod, ws_mod_next;   // window_start modulo the length
  logic [IDX_W-1:0] rd_idx, rd_idx_next;   // (view start + active_column) modulo the length
  logic             pass_next;
  logic             pass;
  logic             req_valid;

  logic [CNT_W-1:0] dwell_inc;
  logic [CNT_W-1:0] frame_inc;
  logic [LEN_W-1:0] len_eff;
  logic [IDX_W-1:0] view_start;

  logic             norm_busy;
  logic [2:0]       norm_step;
  logic [LEN_W:0]   ws_rem, ws_rem_next;
  logic [LEN_W:0]   rd_rem, rd_rem_next;
  logic [LEN_W-1:0] ws_div;
  logic [LEN_W-1:0] rd_div;

  assign len_eff    = eff_len(cfg.sentence_length);
  assign view_start = cfg.scroll_enable ? ws_mod : '0;

  always_comb begin
    dwell_inc          = dwell_count + CNT_W'(1);
    frame_inc          = frame_count + CNT_W'(1);
    dwell_count_next   = dwell_count;
    frame_count_next   = frame_count;
    active_column_next = active_column;
    window_start_next  = window_start;
    ws_mod_next        = ws_mod;
    rd_idx_next        = rd_idx;
    pass_next          = 1'b0;
    if (item_tick) begin
      if (dwell_inc >= at_least_one(cfg.dwell_ticks) || dwell_inc == '0) begin
        dwell_count_next = '0;
        if (active_column == COL_W'(MATRIX_SIZE - 1)) begin
          active_column_next = '0;
          rd_idx_next        = view_start;
          if (frame_inc >= at_least_one(cfg.frame_repeats) || frame_inc == '0) begin
            frame_count_next = '0;
            if (cfg.scroll_enable) begin
              window_start_next = inc_wrap(ws_mod, len_eff);
              ws_mod_next       = window_start_next;
              rd_idx_next       = window_start_next;
              pass_next         = (window_start_next == '0);
            end
          end else begin
            frame_count_next = frame_inc;
          end
        end else begin
          active_column_next = active_column + COL_W'(1);
          rd_idx_next        = inc_wrap(rd_idx, len_eff);
        end
      end else begin
        dwell_count_next = dwell_inc;
      end
    end
  end

  // Bit-serial reduction of the window start and read index against the current length
  assign ws_div      = LEN_W'(window_start);
  assign rd_div      = (cfg.scroll_enable ? LEN_W'(window_start) : '0) + LEN_W'(active_column);
  assign ws_rem_next = rem_step(ws_rem, ws_div[norm_step], len_eff);
  assign rd_rem_next = rem_step(rd_rem, rd_div[norm_step], len_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      dwell_count   <= '0;
      frame_count   <= '0;
      active_column <= '0;
      window_start  <= '0;
      ws_mod        <= '0;
      rd_idx        <= '0;
      pass          <= 1'b0;
      req_valid     <= 1'b0;
      norm_busy     <= 1'b0;
      norm_step     <= '0;
      ws_rem        <= '0;
      rd_rem        <= '0;
    end else begin
      req_valid <= item_accept;
      // Restart the reduction on every register write
      if (cfg_wr) begin
        norm_busy <= 1'b1;
        norm_step <= 3'(LEN_W - 1);
        ws_rem    <= '0;
        rd_rem    <= '0;
      end else if (norm_busy) begin
        ws_rem    <= ws_rem_next;
        rd_rem    <= rd_rem_next;
        norm_step <= norm_step - 3'd1;
        if (norm_step == '0) norm_busy <= 1'b0;
      end
      if (norm_busy && !cfg_wr && norm_step == '0) begin
        ws_mod <= ws_rem_next[IDX_W-1:0];
        rd_idx <= rd_rem_next[IDX_W-1:0];
      end else if (item_accept) begin
        dwell_count   <= dwell_count_next;
        frame_count   <= frame_count_next;
        active_column <= active_column_next;
        window_start  <= window_start_next;
        ws_mod        <= ws_mod_next;
        rd_idx        <= rd_idx_next;
        pass          <= pass_next;
      end
    end
  end

  assign busy = norm_busy;

  // Registers now hold the state after the last accepted item
  assign rd_req.valid  = req_valid;
  assign rd_req.addr   = rd_idx;
  assign rd_req.column = active_column;
  assign rd_req.pass   = pass;

endmodule

// ----- hw/rtl/lmss_store.sv -----
// Sentence store: 64 x 8 synchronous memory with one write and one registered read port.
// Turns a read request into a registered result item in the following cycle. Uses lmss_pkg.
`timescale 1ns / 1ps

module lmss_store
  import lmss_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  rd_req_t          rd_req,
  output out_item_t        item
);

  logic [7:0]       mem [MAX_COLUMNS];
  logic [7:0]       rd_data;
  logic [COL_W-1:0] column;
  logic             pass;
  logic             valid;

  // Read returns the old contents when the same entry is written in that cycle
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_req.addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    column <= rd_req.column;
    pass   <= rd_req.pass;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= rd_req.valid;
    end
  end

  assign item.valid           = valid;
  assign item.row_drive       = rd_data;
  assign item.column_enable_n = ~(8'(1) << column);
  assign item.pass_done       = pass;

endmodule

// ----- hw/rtl/lmss_outq.sv -----
// Four-entry result queue in front of the output stream.
// Decouples the read pipeline from a stalling receiver. Uses lmss_pkg.
`timescale 1ns / 1ps

module lmss_outq
  import lmss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  out_item_t item,
  output logic      m_tvalid,
  input  logic      m_tready,
  output logic [15:0] m_tdata,   // [7:0] row_drive, [15:8] column_enable_n
  output logic      m_tlast,     // pass_done
  output logic [2:0] count
);

  logic [16:0] q [4];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic        pop;

  assign m_tvalid = (count != '0);
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (item.valid) begin
      q[wr_ptr] <= {item.pass_done, item.column_enable_n, item.row_drive};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (item.valid) wr_ptr <= wr_ptr + 2'd1;
      if (pop)        rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(item.valid) - 3'(pop);
    end
  end

  assign m_tdata = q[rd_ptr][15:0];
  assign m_tlast = q[rd_ptr][16];

endmodule

// ----- hw/rtl/led_matrix_scroll_scanner.sv -----
// LED matrix scroll scanner, top level: stream ports, register file and the three stages.
// Depends on lmss_pkg, lmss_ctrl, lmss_store and lmss_outq.
//
// Usage:
//   Input stream (s_*): s_tuser is the command, 0 loads column_byte into
//   store entry load_index, 1 is one time tick. Every transfer yields exactly
//   one result transfer on the output stream (m_*): the row levels and
//   active-low column enables after the item, with m_tlast high on the tick
//   that wraps the scroll window back to entry 0.
//   m_tvalid rises once the counter update, the store read and the queue
//   write, each registered, have taken place. Throughput is one item per
//   cycle while s_tready is high. When the receiver stalls, s_tready drops
//   once four results are queued or still in the stages.
//   Registers (APB, byte address): 0x0 dwell_ticks, 0x4 sentence_length,
//   0x8 frame_repeats, 0xC scroll_enable. Write them only while idle; each
//   write holds s_tready low while the window start and read index are
//   reduced modulo the new length, one bit per cycle.
//   Reset clears the counters, window start, pipeline and queue and loads the
//   register defaults; the sentence store keeps its contents and must be
//   loaded before the entries in view are shown.
`timescale 1ns / 1ps

module led_matrix_scroll_scanner
  import lmss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [5:0] load_index, [13:6] column_byte, [15:14] zero
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] row_drive, [15:8] column_enable_n
  output logic        m_tlast,   // pass_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t      cfg;
  rd_req_t   rd_req;
  out_item_t item;
  logic      accept;
  logic      cfg_wr;
  logic      busy;
  logic [2:0] q_count;
  logic [3:0] held;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dwell_ticks     <= CNT_W'(2500);
      cfg.sentence_length <= LEN_W'(8);
      cfg.frame_repeats   <= CNT_W'(1);
      cfg.scroll_enable   <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr)
        ADDR_DWELL_TICKS:     cfg.dwell_ticks     <= pwdata[CNT_W-1:0];
        ADDR_SENTENCE_LENGTH: cfg.sentence_length <= pwdata[LEN_W-1:0];
        ADDR_FRAME_REPEATS:   cfg.frame_repeats   <= pwdata[CNT_W-1:0];
        ADDR_SCROLL_ENABLE:   cfg.scroll_enable   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_DWELL_TICKS:     prdata = 32'(cfg.dwell_ticks);
      ADDR_SENTENCE_LENGTH: prdata = 32'(cfg.sentence_length);
      ADDR_FRAME_REPEATS:   prdata = 32'(cfg.frame_repeats);
      ADDR_SCROLL_ENABLE:   prdata = 32'(cfg.scroll_enable);
      default:              prdata = '0;
    endcase
  end

  // Count queued results plus items still in the two stages
  assign held     = 4'(q_count) + 4'(rd_req.valid) + 4'(item.valid);
  assign s_tready = !busy && (held < 4'd4);
  assign accept   = s_tvalid && s_tready;

  lmss_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cfg_wr      (cfg_wr),
    .item_accept (accept),
    .item_tick   (accept && (s_tuser == CMD_TICK)),
    .busy        (busy),
    .rd_req      (rd_req)
  );

  lmss_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && (s_tuser == CMD_LOAD)),
    .wr_addr (s_tdata[IDX_W-1:0]),
    .wr_data (s_tdata[IDX_W+7:IDX_W]),
    .rd_req  (rd_req),
    .item    (item)
  );

  lmss_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .count    (q_count)
  );

endmodule
